// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the Intel HEX encoder modules.
// No dependencies; included inside module bodies that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/hexe_pkg.sv =====
// Package for the Intel HEX record encoder: formatter state type, record
// command struct, register map constants and ASCII helper functions.
// No dependencies.
package hexe_pkg;

    localparam int APB_AW = 2;
    localparam logic [APB_AW-1:0] REG_START_ADDR = 2'd0;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // The end record ":00000001FF" CR LF is thirteen characters long.
    localparam logic [3:0] END_LAST_IDX = 4'd12;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_COLON,
        ST_CNT_H,
        ST_CNT_L,
        ST_ADH_H,
        ST_ADH_L,
        ST_ADL_H,
        ST_ADL_L,
        ST_TYP_H,
        ST_TYP_L,
        ST_DAT_H,
        ST_DAT_L,
        ST_SUM_H,
        ST_SUM_L,
        ST_CR,
        ST_LF,
        ST_END
    } fmt_state_t;

    typedef struct packed {
        logic [7:0]  count;
        logic [15:0] addr;
        logic        with_end;
    } rec_cmd_t;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10)
        begin
            c = 8'h30 + {4'd0, nib};
        end
        else
        begin
            c = 8'h37 + {4'd0, nib};
        end
        return c;
    endfunction

    function automatic logic [7:0] end_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = CHAR_COLON;
            4'd8:    c = 8'h31;
            4'd9:    c = 8'h46;
            4'd10:   c = 8'h46;
            4'd11:   c = CHAR_CR;
            4'd12:   c = CHAR_LF;
            default: c = CHAR_ZERO;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/hexe_buf.sv =====
// Record buffer memory: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module hexe_buf #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/hexe_fmt.sv =====
// Record formatter: walks one data record (and the end record if asked)
// character by character, reading buffered bytes from hexe_buf.
// Depends on hexe_pkg and assert_macros.svh.
module hexe_fmt #(
    parameter int AW = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  hexe_pkg::rec_cmd_t cmd,
    output logic              busy,
    output logic              rd_en,
    output logic [AW-1:0]     rd_addr,
    input  logic [7:0]        rd_data,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // ascii_char[7:0]
    output logic              m_tlast
);
    import hexe_pkg::*;

    fmt_state_t state_reg, state_next;
    rec_cmd_t   cmd_reg;
    logic [AW-1:0] idx_reg;
    logic [3:0]    end_idx_reg;
    logic [7:0]    sum_reg;
    logic          out_valid_reg;
    logic [7:0]    out_char_reg;
    logic          out_last_reg;

    logic       advance;
    logic       last_data;
    logic [7:0] char_next;
    logic       last_next;
    logic [7:0] neg_sum;

    assign busy      = (state_reg != ST_IDLE);
    assign advance   = busy && (!out_valid_reg || m_tready);
    assign last_data = ((8'(idx_reg) + 8'd1) == cmd_reg.count);
    assign neg_sum   = 8'd0 - sum_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_COLON;
            ST_COLON: if (advance) state_next = ST_CNT_H;
            ST_CNT_H: if (advance) state_next = ST_CNT_L;
            ST_CNT_L: if (advance) state_next = ST_ADH_H;
            ST_ADH_H: if (advance) state_next = ST_ADH_L;
            ST_ADH_L: if (advance) state_next = ST_ADL_H;
            ST_ADL_H: if (advance) state_next = ST_ADL_L;
            ST_ADL_L: if (advance) state_next = ST_TYP_H;
            ST_TYP_H: if (advance) state_next = ST_TYP_L;
            ST_TYP_L: if (advance) state_next = ST_DAT_H;
            ST_DAT_H: if (advance) state_next = ST_DAT_L;
            ST_DAT_L: if (advance) state_next = last_data ? ST_SUM_H : ST_DAT_H;
            ST_SUM_H: if (advance) state_next = ST_SUM_L;
            ST_SUM_L: if (advance) state_next = ST_CR;
            ST_CR:    if (advance) state_next = ST_LF;
            ST_LF:    if (advance) state_next = cmd_reg.with_end ? ST_END : ST_IDLE;
            ST_END:   if (advance && end_idx_reg == END_LAST_IDX) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        char_next = CHAR_ZERO;
        last_next = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        unique case (state_reg)
            ST_COLON:
            begin
                char_next = CHAR_COLON;
                // Fetch the first byte early; it is needed several characters later.
                rd_en     = advance;
            end
            ST_CNT_H: char_next = hex_char(cmd_reg.count[7:4]);
            ST_CNT_L: char_next = hex_char(cmd_reg.count[3:0]);
            ST_ADH_H: char_next = hex_char(cmd_reg.addr[15:12]);
            ST_ADH_L: char_next = hex_char(cmd_reg.addr[11:8]);
            ST_ADL_H: char_next = hex_char(cmd_reg.addr[7:4]);
            ST_ADL_L: char_next = hex_char(cmd_reg.addr[3:0]);
            ST_DAT_H: char_next = hex_char(rd_data[7:4]);
            ST_DAT_L:
            begin
                char_next = hex_char(rd_data[3:0]);
                rd_en     = advance && !last_data;
                rd_addr   = idx_reg + AW'(1);
            end
            ST_SUM_H: char_next = hex_char(neg_sum[7:4]);
            ST_SUM_L: char_next = hex_char(neg_sum[3:0]);
            ST_CR:    char_next = CHAR_CR;
            ST_LF:
            begin
                char_next = CHAR_LF;
                last_next = !cmd_reg.with_end;
            end
            ST_END:
            begin
                char_next = end_char(end_idx_reg);
                last_next = (end_idx_reg == END_LAST_IDX);
            end
            default:
            begin
                char_next = CHAR_ZERO;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg     <= cmd;
            idx_reg     <= '0;
            end_idx_reg <= '0;
            sum_reg     <= cmd.count + cmd.addr[15:8] + cmd.addr[7:0];
        end
        else if (advance)
        begin
            if (state_reg == ST_DAT_H)
            begin
                sum_reg <= sum_reg + rd_data;
            end
            if (state_reg == ST_DAT_L)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            if (state_reg == ST_END)
            begin
                end_idx_reg <= end_idx_reg + 4'd1;
            end
        end
        if (advance)
        begin
            out_char_reg <= char_next;
            out_last_reg <= last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

    `include "assert_macros.svh"

    `ASSERT_HOLDS(a_start_idle, clk, rst_n, start |-> state_reg == ST_IDLE, "record started while busy")
    `ASSERT_HOLDS(a_idx_in_count, clk, rst_n, (state_reg == ST_DAT_H) |-> (8'(idx_reg) < cmd_reg.count), "data index beyond record count")
    `ASSERT_HOLDS(a_adv_loads, clk, rst_n, advance |=> out_valid_reg, "character lost from output register")

endmodule

// ===== hdl/intel_hex_record_encoder.sv =====
// Intel HEX record encoder. A byte that does not close a record is taken when the
// formatter is idle. A record of n bytes gives 13 + 2n characters, one a cycle while
// the sink takes them; the end record adds 13 more.
// No new byte is taken until the formatter has loaded the last character of a record.
// Reset (rst_n, asynchronous) clears fill count, address and start address to zero;
// the record buffer needs no clearing since only bytes of the current record are read.
module intel_hex_record_encoder #(
    parameter int RECORD_BYTES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // data_byte[7:0]
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,   // ascii_char[7:0]
    output logic                         m_tlast,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hexe_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import hexe_pkg::*;

    localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int CW = $clog2(RECORD_BYTES + 1);

    logic [15:0]   start_addr_reg;
    logic [15:0]   cur_addr_reg, cur_addr_next;
    logic [CW-1:0] fill_count_reg, fill_count_next;

    logic          cfg_wr;
    logic          in_acc;
    logic          flush;
    logic [7:0]    rec_count;
    rec_cmd_t      cmd;
    logic          fmt_busy;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && (paddr == REG_START_ADDR);
    assign prdata  = (paddr == REG_START_ADDR) ? {16'd0, start_addr_reg} : 32'd0;

    assign s_tready  = !fmt_busy;
    assign in_acc    = s_tvalid && s_tready;
    assign rec_count = 8'(fill_count_reg) + 8'd1;
    assign flush     = (32'(fill_count_reg) + 32'd1 == RECORD_BYTES) || s_tlast;

    assign cmd.count    = rec_count;
    assign cmd.addr     = cur_addr_reg;
    assign cmd.with_end = s_tlast;

    always_comb
    begin
        fill_count_next = fill_count_reg;
        cur_addr_next   = cur_addr_reg;
        if (in_acc)
        begin
            fill_count_next = flush ? '0 : (fill_count_reg + CW'(1));
        end
        priority if (cfg_wr)
        begin
            cur_addr_next = pwdata[15:0];
        end
        else if (in_acc && flush)
        begin
            cur_addr_next   = s_tlast ? start_addr_reg : (cur_addr_reg + {8'd0, rec_count});
        end
        else
        begin
            cur_addr_next = cur_addr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_addr_reg <= '0;
            cur_addr_reg   <= '0;
            fill_count_reg <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                start_addr_reg <= pwdata[15:0];
            end
            cur_addr_reg   <= cur_addr_next;
            fill_count_reg <= fill_count_next;
        end
    end

    hexe_buf #(
        .DEPTH (RECORD_BYTES),
        .AW    (AW)
    ) u_buf (
        .clk     (clk),
        .wr_en   (in_acc),
        .wr_addr (fill_count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    hexe_fmt #(
        .AW (AW)
    ) u_fmt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_acc && flush),
        .cmd      (cmd),
        .busy     (fmt_busy),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    `include "assert_macros.svh"

    `ASSERT_HOLDS(a_fill_room, clk, rst_n,
        in_acc |-> (32'(fill_count_reg) < RECORD_BYTES), "byte accepted into full buffer")
    `ASSERT_HOLDS(a_flush_clears, clk, rst_n,
        (in_acc && flush) |=> (fill_count_reg == '0), "fill count not cleared after record")

endmodule
